[design/grid_astar_path_search_macros.svh]
// assertion macros of the grid path search rtl
// no dependencies; taken in by files that check their own logic
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

// same-cycle implication under the synchronous active-low reset
`define GASP_CHK_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under the synchronous active-low reset
`define GASP_CHK_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[design/gasp_pkg.sv]
// types and constants of the grid path search block
// no dependencies; used by gasp_out and the top level
`timescale 1ns / 1ps

package gasp_pkg;

  // grid bounds; the memories are sized for them
  localparam int MAX_COLS = 8;
  localparam int MAX_ROWS = 8;

  localparam int CRDW = 4;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TILE_SIZE  = 2'd2;

  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic [15:0] COST_STRAIGHT = 16'd10;
  localparam logic [15:0] COST_DIAG     = 16'd14;
  localparam logic [4:0]  H_SCALE       = 5'd10;

  localparam logic [6:0] K_LAST = 7'd63;
  localparam logic [6:0] K_MAX  = 7'd64;

  typedef logic [CRDW-1:0] crd_t;

  typedef struct packed {
    logic [15:0] f;
    crd_t        x;
    crd_t        y;
  } heap_ent_t;

  typedef struct packed {
    logic found;
    crd_t x;
    crd_t y;
    logic last;
  } out_req_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CHK, ST_CHK2, ST_CLR, ST_POP, ST_POP2, ST_SD, ST_SD2,
    ST_GRD, ST_GRD2, ST_NB, ST_NB2, ST_NB3, ST_SU, ST_SU2, ST_SUF, ST_ADV,
    ST_PATH, ST_PATH2, ST_EMIT, ST_EMIT2, ST_FAIL
  } gasp_state_t;

endpackage

[design/gasp_if.sv]
// valid/ready channels of the grid path search block: request and result
// depends on nothing but the language
`timescale 1ns / 1ps

interface gasp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] cell_x;
  logic [2:0] cell_y;
  logic       blocked;
  logic [2:0] goal_x;
  logic [2:0] goal_y;

  modport source (output valid, cmd, cell_x, cell_y, blocked, goal_x, goal_y, input ready);
  modport sink (input valid, cmd, cell_x, cell_y, blocked, goal_x, goal_y, output ready);
endinterface

interface gasp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  step_x;
  logic [2:0]  step_y;
  logic [13:0] pixel_x;
  logic [13:0] pixel_y;
  logic        last;

  modport source (output valid, found, step_x, step_y, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, found, step_x, step_y, pixel_x, pixel_y, last, output ready);
endinterface

[design/grid_astar_path_search.sv]
// top level of the grid path search: sequencer, grid and open-list memories
// depends on gasp_pkg, gasp_if, gasp_out and grid_astar_path_search_macros.svh
`timescale 1ns / 1ps

// 8-neighbour A* search on a grid of up to MAX_COLS x MAX_ROWS cells. A search
// request runs its checks, then a pass that clears the cell marks, then for
// each expanded cell a pop with a heap sift-down, and per neighbour its checks
// with a heap sift-up; then comes the path walk, then the results, which the
// output can stall. The open list and per-cell state sit in registered-read
// memories, so the sequencer's read-modify-write of them sets the pace. After
// reset the block clears the grid before it takes requests; configuration
// writes take effect at once and belong between requests.
module grid_astar_path_search
  import gasp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  gasp_in_if.sink    in_chan,
  gasp_out_if.source out_chan
);

`include "grid_astar_path_search_macros.svh"

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int CW     = $clog2(NCELLS);
  localparam int HW     = $clog2(NCELLS + 1);

  function automatic logic [CW-1:0] cell_key(input crd_t x, input crd_t y);
    return CW'(y * MAX_COLS + x);
  endfunction

  // configuration
  logic [3:0] map_width_r, map_height_r;
  logic [7:0] tile_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 4'd8;
      map_height_r <= 4'd8;
      tile_size_r  <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata[3:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_wdata[3:0];
        CFG_TILE_SIZE:  tile_size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crd_t weff, heff;
  assign weff = (int'(map_width_r) > MAX_COLS) ? CRDW'(MAX_COLS) : map_width_r;
  assign heff = (int'(map_height_r) > MAX_ROWS) ? CRDW'(MAX_ROWS) : map_height_r;

  // memories and their ports
  logic            walk_mem [NCELLS];
  logic [1:0]      mark_mem [NCELLS];
  logic [15:0]     g_mem    [NCELLS];
  logic [7:0]      par_mem  [NCELLS];
  logic [HW-1:0]   pos_mem  [NCELLS];
  heap_ent_t       heap_mem [NCELLS+1];
  logic [7:0]      stk_mem  [NCELLS];

  logic            walk_we, walk_wd;
  logic [CW-1:0]   walk_wa, walk_ra, walk_rb;
  logic            walk_qa_r, walk_qb_r;
  logic            mark_we;
  logic [1:0]      mark_wd, mark_q_r;
  logic [CW-1:0]   mark_wa, mark_ra;
  logic            g_we;
  logic [15:0]     g_wd, g_q_r;
  logic [CW-1:0]   g_wa, g_ra;
  logic            par_we;
  logic [7:0]      par_wd, par_q_r;
  logic [CW-1:0]   par_wa, par_ra;
  logic            pos_we;
  logic [HW-1:0]   pos_wd, pos_q_r;
  logic [CW-1:0]   pos_wa, pos_ra;
  logic            heap_we;
  heap_ent_t       heap_wd, heap_qa_r, heap_qb_r;
  logic [HW-1:0]   heap_wa, heap_ra, heap_rb;
  logic            stk_we;
  logic [7:0]      stk_wd, stk_q_r;
  logic [CW-1:0]   stk_wa, stk_ra;

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_qa_r <= walk_mem[walk_ra];
    walk_qb_r <= walk_mem[walk_rb];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q_r <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    g_q_r <= g_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_q_r <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_qa_r <= heap_mem[heap_ra];
    heap_qb_r <= heap_mem[heap_rb];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q_r <= stk_mem[stk_ra];
  end

  // sequencer registers
  gasp_state_t   state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  crd_t          sx_r, sy_r, tx_r, ty_r, sx_nxt, sy_nxt, tx_nxt, ty_nxt;
  crd_t          px_r, py_r, px_nxt, py_nxt;
  crd_t          pcx_r, pcy_r, pcx_nxt, pcy_nxt;
  logic [HW-1:0] cnt_r, cnt_nxt, m_r, m_nxt, pn_r, pn_nxt;
  logic [15:0]   pg_r, pg_nxt, gc_r, gc_nxt;
  logic [1:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic [1:0]    mk_r, mk_nxt;
  logic          blk_r, blk_nxt, side_r, side_nxt;
  logic [HW-1:0] posc_r, posc_nxt;
  heap_ent_t     ent_r, ent_nxt;
  logic          strict_r, strict_nxt, hit_r, hit_nxt;
  logic [6:0]    k_r, k_nxt;

  logic          out_load, out_free;
  out_req_t      out_req;

  // neighbour under test
  crd_t          nb_a, nb_b, hdx, hdy;
  logic          nb_oob, nb_center, diag;
  logic [15:0]   ng, fnew;
  logic [8:0]    hcost;
  logic [CW-1:0] nb_key;
  logic          in_acc;

  assign nb_a      = px_r + CRDW'(dx_r) - CRDW'(1);
  assign nb_b      = py_r + CRDW'(dy_r) - CRDW'(1);
  assign nb_oob    = (px_r == '0 && dx_r == 2'd0) || (py_r == '0 && dy_r == 2'd0) ||
                     nb_a >= weff || nb_b >= heff;
  assign nb_center = dx_r == 2'd1 && dy_r == 2'd1;
  assign diag      = dx_r != 2'd1 && dy_r != 2'd1;
  assign nb_key    = cell_key(nb_a, nb_b);
  assign ng        = pg_r + (diag ? COST_DIAG : COST_STRAIGHT);
  assign hdx       = (nb_a > tx_r) ? nb_a - tx_r : tx_r - nb_a;
  assign hdy       = (nb_b > ty_r) ? nb_b - ty_r : ty_r - nb_b;
  assign hcost     = (9'(hdx) + 9'(hdy)) * 9'(H_SCALE);
  assign fnew      = ng + 16'(hcost);
  assign in_acc    = in_chan.valid && in_chan.ready;

  // sift-down children
  logic [HW:0] lidx, ridx;
  logic        has_l, has_r, sel_l, sel_r;
  logic [15:0] cur_f;
  assign lidx  = {m_r, 1'b0};
  assign ridx  = lidx + (HW+1)'(1);
  assign has_l = lidx <= (HW+1)'(cnt_r);
  assign has_r = ridx <= (HW+1)'(cnt_r);
  assign sel_l = has_l && (ent_r.f >= heap_qa_r.f);
  assign cur_f = sel_l ? heap_qa_r.f : ent_r.f;
  assign sel_r = has_r && (cur_f >= heap_qb_r.f);

  // request checks on the latched search
  logic tgt_in, src_in;
  assign tgt_in = tx_r < weff && ty_r < heff;
  assign src_in = sx_r < weff && sy_r < heff;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pcx_nxt    = pcx_r;
    pcy_nxt    = pcy_r;
    cnt_nxt    = cnt_r;
    m_nxt      = m_r;
    pn_nxt     = pn_r;
    pg_nxt     = pg_r;
    gc_nxt     = gc_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    mk_nxt     = mk_r;
    blk_nxt    = blk_r;
    side_nxt   = side_r;
    posc_nxt   = posc_r;
    ent_nxt    = ent_r;
    strict_nxt = strict_r;
    hit_nxt    = hit_r;
    k_nxt      = k_r;

    in_chan.ready = 1'b0;
    walk_we = 1'b0;  walk_wa = '0;  walk_wd = 1'b0;
    walk_ra = nb_key; walk_rb = cell_key(nb_a, py_r);
    mark_we = 1'b0;  mark_wa = '0;  mark_wd = MARK_NONE; mark_ra = nb_key;
    g_we    = 1'b0;  g_wa    = nb_key; g_wd = ng;  g_ra = nb_key;
    par_we  = 1'b0;  par_wa  = nb_key; par_wd = {px_r, py_r};
    par_ra  = cell_key(pcx_r, pcy_r);
    pos_we  = 1'b0;  pos_wa  = '0;  pos_wd = m_r;  pos_ra = nb_key;
    heap_we = 1'b0;  heap_wa = m_r; heap_wd = ent_r;
    heap_ra = HW'(1); heap_rb = cnt_r;
    stk_we  = 1'b0;  stk_wa  = pn_r[CW-1:0]; stk_wd = {pcx_r, pcy_r};
    stk_ra  = CW'(pn_r - HW'(1));
    out_load = 1'b0;
    out_req  = '{found: 1'b0, x: '0, y: '0, last: 1'b1};

    unique case (state_r)
      ST_INIT: begin
        walk_we = 1'b1;  walk_wa = clr_r;
        mark_we = 1'b1;  mark_wa = clr_r;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(NCELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_acc) begin
          if (!in_chan.cmd) begin
            walk_we = int'(in_chan.cell_x) < MAX_COLS && int'(in_chan.cell_y) < MAX_ROWS;
            walk_wa = cell_key(CRDW'(in_chan.cell_x), CRDW'(in_chan.cell_y));
            walk_wd = in_chan.blocked;
          end else begin
            sx_nxt    = CRDW'(in_chan.cell_x);
            sy_nxt    = CRDW'(in_chan.cell_y);
            tx_nxt    = CRDW'(in_chan.goal_x);
            ty_nxt    = CRDW'(in_chan.goal_y);
            clr_nxt   = '0;
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        walk_ra   = tgt_in ? cell_key(tx_r, ty_r) : '0;
        state_nxt = ST_CHK2;
      end
      ST_CHK2: begin
        if ((sx_r == tx_r && sy_r == ty_r) || !src_in || !tgt_in || walk_qa_r) begin
          state_nxt = ST_FAIL;
        end else begin
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        mark_we = 1'b1;  mark_wa = clr_r;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(NCELLS - 1)) begin
          // seed the open list with the start cell
          g_we    = 1'b1;  g_wa = cell_key(sx_r, sy_r);  g_wd = '0;
          heap_we = 1'b1;  heap_wa = HW'(1);
          heap_wd = '{f: 16'd0, x: sx_r, y: sy_r};
          pos_we  = 1'b1;  pos_wa = cell_key(sx_r, sy_r);  pos_wd = HW'(1);
          cnt_nxt = HW'(1);
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FAIL;
        end else begin
          state_nxt = ST_POP2;
        end
      end
      ST_POP2: begin
        px_nxt  = heap_qa_r.x;
        py_nxt  = heap_qa_r.y;
        ent_nxt = heap_qb_r;
        cnt_nxt = cnt_r - HW'(1);
        m_nxt   = HW'(1);
        hit_nxt = 1'b0;
        mark_we = 1'b1;
        mark_wa = cell_key(heap_qa_r.x, heap_qa_r.y);
        mark_wd = MARK_CLOSED;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        heap_ra   = (lidx <= (HW+1)'(NCELLS)) ? HW'(lidx) : '0;
        heap_rb   = (ridx <= (HW+1)'(NCELLS)) ? HW'(ridx) : '0;
        state_nxt = ST_SD2;
      end
      ST_SD2: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (sel_r) begin
          heap_wd = heap_qb_r;
          pos_wa  = cell_key(heap_qb_r.x, heap_qb_r.y);
          m_nxt   = HW'(ridx);
          state_nxt = ST_SD;
        end else if (sel_l) begin
          heap_wd = heap_qa_r;
          pos_wa  = cell_key(heap_qa_r.x, heap_qa_r.y);
          m_nxt   = HW'(lidx);
          state_nxt = ST_SD;
        end else begin
          heap_wd = ent_r;
          pos_wa  = cell_key(ent_r.x, ent_r.y);
          state_nxt = ST_GRD;
        end
      end
      ST_GRD: begin
        g_ra      = cell_key(px_r, py_r);
        state_nxt = ST_GRD2;
      end
      ST_GRD2: begin
        pg_nxt    = g_q_r;
        dx_nxt    = 2'd0;
        dy_nxt    = 2'd0;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        if (nb_oob || nb_center) begin
          state_nxt = ST_ADV;
        end else begin
          state_nxt = ST_NB2;
        end
      end
      ST_NB2: begin
        mk_nxt    = mark_q_r;
        blk_nxt   = walk_qa_r;
        side_nxt  = walk_qb_r;
        gc_nxt    = g_q_r;
        posc_nxt  = pos_q_r;
        walk_rb   = cell_key(px_r, nb_b);
        state_nxt = ST_NB3;
      end
      ST_NB3: begin
        state_nxt = ST_ADV;
        if (mk_r == MARK_CLOSED || blk_r || (diag && (side_r || walk_qb_r))) begin
          state_nxt = ST_ADV;
        end else if (mk_r != MARK_OPEN) begin
          g_we    = 1'b1;
          par_we  = 1'b1;
          mark_we = 1'b1;  mark_wa = nb_key;  mark_wd = MARK_OPEN;
          ent_nxt = '{f: fnew, x: nb_a, y: nb_b};
          m_nxt   = cnt_r + HW'(1);
          cnt_nxt = cnt_r + HW'(1);
          strict_nxt = 1'b0;
          if (nb_a == tx_r && nb_b == ty_r) begin
            hit_nxt = 1'b1;
          end
          state_nxt = ST_SU;
        end else if (ng < gc_r) begin
          // shorter route to a cell already on the open list
          g_we    = 1'b1;
          par_we  = 1'b1;
          ent_nxt = '{f: fnew, x: nb_a, y: nb_b};
          m_nxt   = posc_r;
          strict_nxt = 1'b1;
          state_nxt  = ST_SU;
        end
      end
      ST_SU: begin
        heap_ra = m_r >> 1;
        if (m_r == HW'(1)) begin
          state_nxt = ST_SUF;
        end else begin
          state_nxt = ST_SU2;
        end
      end
      ST_SU2: begin
        if (strict_r ? (ent_r.f < heap_qa_r.f) : (ent_r.f <= heap_qa_r.f)) begin
          heap_we = 1'b1;  heap_wd = heap_qa_r;
          pos_we  = 1'b1;  pos_wa = cell_key(heap_qa_r.x, heap_qa_r.y);
          m_nxt   = m_r >> 1;
          state_nxt = ST_SU;
        end else begin
          state_nxt = ST_SUF;
        end
      end
      ST_SUF: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;  pos_wa = cell_key(ent_r.x, ent_r.y);
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (dx_r == 2'd2) begin
          dx_nxt = 2'd0;
          dy_nxt = dy_r + 2'd1;
          if (dy_r == 2'd2) begin
            if (hit_r) begin
              pcx_nxt   = tx_r;
              pcy_nxt   = ty_r;
              pn_nxt    = '0;
              state_nxt = ST_PATH;
            end else begin
              state_nxt = ST_POP;
            end
          end else begin
            state_nxt = ST_NB;
          end
        end else begin
          dx_nxt    = dx_r + 2'd1;
          state_nxt = ST_NB;
        end
      end
      ST_PATH: begin
        stk_we    = 1'b1;
        pn_nxt    = pn_r + HW'(1);
        state_nxt = ST_PATH2;
      end
      ST_PATH2: begin
        pcx_nxt = par_q_r[7:4];
        pcy_nxt = par_q_r[3:0];
        if ((par_q_r[7:4] == sx_r && par_q_r[3:0] == sy_r) || pn_r == HW'(NCELLS)) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PATH;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_EMIT2;
      end
      ST_EMIT2: begin
        if (out_free) begin
          out_load = 1'b1;
          out_req  = '{found: 1'b1, x: stk_q_r[7:4], y: stk_q_r[3:0],
                       last: (pn_r == HW'(1)) || (k_r == K_LAST)};
          pn_nxt   = pn_r - HW'(1);
          k_nxt    = k_r + 7'd1;
          if ((pn_r == HW'(1)) || (k_r == K_LAST)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pcx_r    <= pcx_nxt;
    pcy_r    <= pcy_nxt;
    cnt_r    <= cnt_nxt;
    m_r      <= m_nxt;
    pn_r     <= pn_nxt;
    pg_r     <= pg_nxt;
    gc_r     <= gc_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    mk_r     <= mk_nxt;
    blk_r    <= blk_nxt;
    side_r   <= side_nxt;
    posc_r   <= posc_nxt;
    ent_r    <= ent_nxt;
    strict_r <= strict_nxt;
    hit_r    <= hit_nxt;
    k_r      <= k_nxt;
  end

  gasp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .req       (out_req),
    .tile_size (tile_size_r),
    .free      (out_free),
    .out_chan  (out_chan)
  );

  `GASP_CHK_IMPL(a_load_free, clk, rst_n, out_load, out_free, "result loaded over a pending one")
  `GASP_CHK_NEXT(a_search_start, clk, rst_n, in_acc && in_chan.cmd, state_r == ST_CHK,
    "search transfer did not start the checks")
  `GASP_CHK_IMPL(a_sift_slot, clk, rst_n, state_r == ST_SU, m_r != '0, "sift-up at heap slot zero")
  `GASP_CHK_IMPL(a_result_cap, clk, rst_n, state_r == ST_EMIT2, k_r < K_MAX,
    "more results than the cap")

endmodule

[design/gasp_out.sv]
// result register of the path search: holds one result and forms pixel coordinates
// depends on gasp_pkg and gasp_out_if
`timescale 1ns / 1ps

module gasp_out
  import gasp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  out_req_t         req,
  input  logic [7:0]       tile_size,
  output logic             free,
  gasp_out_if.source       out_chan
);

  logic        valid_r, valid_nxt;
  out_req_t    req_r;
  logic [13:0] pix_x_r, pix_y_r;
  logic [13:0] pix_x_nxt, pix_y_nxt;

  assign free = !valid_r || out_chan.ready;

  // tile center: step * tile + tile / 2, zero for a failed search
  assign pix_x_nxt = req.found ?
                     (14'(req.x) * 14'(tile_size) + 14'(tile_size >> 1)) : '0;
  assign pix_y_nxt = req.found ?
                     (14'(req.y) * 14'(tile_size) + 14'(tile_size >> 1)) : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r   <= req;
      pix_x_r <= pix_x_nxt;
      pix_y_r <= pix_y_nxt;
    end
  end

  assign out_chan.valid   = valid_r;
  assign out_chan.found   = req_r.found;
  assign out_chan.step_x  = req_r.x[2:0];
  assign out_chan.step_y  = req_r.y[2:0];
  assign out_chan.pixel_x = pix_x_r;
  assign out_chan.pixel_y = pix_y_r;
  assign out_chan.last    = req_r.last;

endmodule
